// ===== hw/rtl/ppmfd_pkg.sv =====
// ----------------------------------------------------------------------------
// ppmfd_pkg
// Shared types and constants for the PPM frame decoder.
// ----------------------------------------------------------------------------
package ppmfd_pkg;

    // Command codes carried by each input beat.
    localparam logic [1:0] CMD_EDGE    = 2'd0;
    localparam logic [1:0] CMD_TIMEOUT = 2'd1;
    localparam logic [1:0] CMD_TICK    = 2'd2;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_REVERSE_MASK = 2'd0;
    localparam logic [1:0] REG_GOOD_LIMIT   = 2'd1;
    localparam logic [1:0] REG_ACCEPT_LOW   = 2'd2;
    localparam logic [1:0] REG_ACCEPT_HIGH  = 2'd3;

    // Register reset values.
    localparam logic [7:0]  RST_REVERSE_MASK = 8'd0;
    localparam logic [7:0]  RST_GOOD_LIMIT   = 8'd10;
    localparam logic [15:0] RST_ACCEPT_LOW   = 16'd800;
    localparam logic [15:0] RST_ACCEPT_HIGH  = 16'd2200;

    // Pulse clamp window and scaling offset.
    localparam logic [15:0] CLAMP_LO   = 16'd1000;
    localparam logic [15:0] CLAMP_HI   = 16'd2000;
    localparam logic [7:0]  FULL_SCALE = 8'hff;

    // Signal loss supervision.
    localparam logic [8:0] LOST_TRIP = 9'd100;
    localparam logic [7:0] LOST_PIN  = 8'd200;

    // Number of channels that have a reverse bit.
    localparam int MASK_CHANNELS = 8;

    typedef struct packed {
        logic [7:0]  reverse_mask;
        logic [7:0]  good_limit;
        logic [15:0] accept_low;
        logic [15:0] accept_high;
    } cfg_t;

    typedef struct packed {
        logic        write_valid;
        logic [2:0]  channel_index;
        logic [7:0]  channel_value;
        logic        frame_done;
        logic        out_of_range;
        logic [7:0]  good_level;
        logic [7:0]  lost_count;
    } result_t;

endpackage

// ===== hw/rtl/ppmfd_core.sv =====
// ----------------------------------------------------------------------------
// ppmfd_core
// Decoder state and the single-pass command logic. The state advances on
// every beat that leaves the input register.
// ----------------------------------------------------------------------------
module ppmfd_core #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [1:0]          command,
    input  logic [15:0]         interval_us,
    input  ppmfd_pkg::cfg_t     cfg,
    output ppmfd_pkg::result_t  res
);

    localparam int CH_W = $clog2(NUM_CHANNELS);

    logic [CH_W-1:0] chan_reg;
    logic [CH_W-1:0] chan_next;
    logic            sync_reg;
    logic            sync_next;
    logic [7:0]      good_reg;
    logic [7:0]      good_next;
    logic [7:0]      lost_reg;
    logic [7:0]      lost_next;

    logic [4:0]  chan_wide;
    logic        in_window;
    logic [15:0] clamped;
    logic [15:0] offset;
    logic [7:0]  scaled;
    logic        reverse;
    logic        last_chan;
    logic [8:0]  lost_inc;
    logic [7:0]  good_dec;

    // Clamp, scale and optional inversion of the pulse width.
    always_comb
    begin
        chan_wide = 5'(chan_reg);
        in_window = (interval_us >= cfg.accept_low) && (interval_us <= cfg.accept_high);
        if (interval_us > ppmfd_pkg::CLAMP_HI)
        begin
            clamped = ppmfd_pkg::CLAMP_HI;
        end
        else if (interval_us < ppmfd_pkg::CLAMP_LO)
        begin
            clamped = ppmfd_pkg::CLAMP_LO;
        end
        else
        begin
            clamped = interval_us;
        end
        offset    = clamped - ppmfd_pkg::CLAMP_LO;
        reverse   = (chan_wide < 5'(ppmfd_pkg::MASK_CHANNELS))
                    && cfg.reverse_mask[chan_wide[2:0]];
        scaled    = reverse ? (ppmfd_pkg::FULL_SCALE - offset[9:2]) : offset[9:2];
        last_chan = (chan_reg == CH_W'(NUM_CHANNELS - 1));
        lost_inc  = {1'b0, lost_reg} + 9'd1;
        good_dec  = (good_reg != 8'd0) ? (good_reg - 8'd1) : good_reg;
    end

    // Next state and result for the command in the input register.
    always_comb
    begin
        chan_next = chan_reg;
        sync_next = sync_reg;
        good_next = good_reg;
        lost_next = lost_reg;
        res       = '0;
        unique case (command)
            ppmfd_pkg::CMD_EDGE:
            begin
                if (sync_reg)
                begin
                    sync_next = 1'b0;
                    chan_next = '0;
                end
                else if (!in_window)
                begin
                    res.out_of_range = 1'b1;
                    chan_next        = '0;
                    good_next        = good_dec;
                end
                else
                begin
                    res.write_valid   = 1'b1;
                    res.channel_index = chan_wide[2:0];
                    res.channel_value = scaled;
                    if (last_chan)
                    begin
                        chan_next      = '0;
                        res.frame_done = 1'b1;
                        if (good_reg < cfg.good_limit)
                        begin
                            good_next = good_reg + 8'd1;
                        end
                    end
                    else
                    begin
                        chan_next = chan_reg + CH_W'(1);
                    end
                end
            end
            ppmfd_pkg::CMD_TIMEOUT:
            begin
                sync_next = 1'b1;
            end
            ppmfd_pkg::CMD_TICK:
            begin
                if (sync_reg)
                begin
                    if (lost_inc > ppmfd_pkg::LOST_TRIP)
                    begin
                        lost_next = ppmfd_pkg::LOST_PIN;
                        good_next = good_dec;
                    end
                    else
                    begin
                        lost_next = lost_inc[7:0];
                    end
                end
                else
                begin
                    lost_next = 8'd0;
                end
            end
            ppmfd_pkg::CMD_UNUSED:
            begin
                chan_next = chan_reg;
            end
            default:
            begin
                chan_next = chan_reg;
            end
        endcase
        res.good_level = good_next;
        res.lost_count = lost_next;
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg <= '0;
            sync_reg <= 1'b0;
            good_reg <= 8'd0;
            lost_reg <= 8'd0;
        end
        else if (fire)
        begin
            chan_reg <= chan_next;
            sync_reg <= sync_next;
            good_reg <= good_next;
            lost_reg <= lost_next;
        end
    end

endmodule

// ===== hw/rtl/ppm_frame_decoder_top.sv =====
// An accepted input beat is held in the input register, then in the result register.
// Throughput: one item per cycle; the input register and the result register
// form a two-stage pipeline that moves whenever the result stage is free.
// Reset: rst_n is asynchronous and active low; it clears the decoder state,
// the pipeline valid bits and loads the configuration registers' defaults.
// ----------------------------------------------------------------------------
// ppm_frame_decoder_top
// PPM frame decoder: input register, command logic and result register.
// ----------------------------------------------------------------------------
module ppm_frame_decoder_top #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // Input channel.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [15:0] interval_us,
    // Result channel.
    output logic        out_valid,
    input  logic        out_stall,
    output logic        write_valid,
    output logic [2:0]  channel_index,
    output logic [7:0]  channel_value,
    output logic        frame_done,
    output logic        out_of_range,
    output logic [7:0]  good_level,
    output logic [7:0]  lost_count
);

    ppmfd_pkg::cfg_t    cfg_reg;
    ppmfd_pkg::result_t res;
    ppmfd_pkg::result_t res_reg;

    logic        in_v_reg;
    logic [1:0]  cmd_reg;
    logic [15:0] iv_reg;
    logic        out_v_reg;
    logic        out_adv;
    logic        fire;

    // Pipeline flow control.
    assign out_adv  = !out_v_reg || !out_stall;
    assign fire     = in_v_reg && out_adv;
    assign in_stall = in_v_reg && !out_adv;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reverse_mask <= ppmfd_pkg::RST_REVERSE_MASK;
            cfg_reg.good_limit   <= ppmfd_pkg::RST_GOOD_LIMIT;
            cfg_reg.accept_low   <= ppmfd_pkg::RST_ACCEPT_LOW;
            cfg_reg.accept_high  <= ppmfd_pkg::RST_ACCEPT_HIGH;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ppmfd_pkg::REG_REVERSE_MASK: cfg_reg.reverse_mask <= cfg_data[7:0];
                ppmfd_pkg::REG_GOOD_LIMIT:   cfg_reg.good_limit   <= cfg_data[7:0];
                ppmfd_pkg::REG_ACCEPT_LOW:   cfg_reg.accept_low   <= cfg_data;
                ppmfd_pkg::REG_ACCEPT_HIGH:  cfg_reg.accept_high  <= cfg_data;
                default:                     cfg_reg.accept_high  <= cfg_data;
            endcase
        end
    end

    // Input register valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_v_reg <= in_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            cmd_reg <= command;
            iv_reg  <= interval_us;
        end
    end

    ppmfd_core #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .command     (cmd_reg),
        .interval_us (iv_reg),
        .cfg         (cfg_reg),
        .res         (res)
    );

    // Result register valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_v_reg <= in_v_reg;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res;
        end
    end

    assign out_valid     = out_v_reg;
    assign write_valid   = res_reg.write_valid;
    assign channel_index = res_reg.channel_index;
    assign channel_value = res_reg.channel_value;
    assign frame_done    = res_reg.frame_done;
    assign out_of_range  = res_reg.out_of_range;
    assign good_level    = res_reg.good_level;
    assign lost_count    = res_reg.lost_count;

`ifndef SYNTHESIS
    // A completed frame always carries a channel value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> write_valid)
        else $error("frame_done without a channel value");

    // A rejected interval never produces a channel value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && write_valid |-> !out_of_range)
        else $error("channel value on an out-of-range interval");

    // The lost counter is either counting up to the trip point or pinned.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (lost_count <= 8'd100) || (lost_count == ppmfd_pkg::LOST_PIN))
        else $error("lost counter outside its range");

    // The input stage only holds off while a result waits downstream.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while the result stage is free");
`endif

endmodule
